/* design/cci_pkg.sv */
package cci_pkg;

	// access codes
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// word indexes inside one channel block
	localparam logic [13:0] W_CTRL    = 14'd0;
	localparam logic [13:0] W_IMG_CFG = 14'd3;
	localparam logic [13:0] W_IER     = 14'd4;
	localparam logic [13:0] W_STS     = 14'd5;
	localparam logic [13:0] W_BUF1    = 14'd28;  // byte offset 0x70
	localparam logic [13:0] W_PITCH   = 14'd31;  // byte offset 0x7c
	localparam logic [13:0] W_BUF2    = 14'd35;  // byte offset 0x8c
	localparam logic [13:0] W_XT1     = 14'd40;  // byte offset 0xa0
	localparam logic [13:0] W_XT2     = 14'd43;  // byte offset 0xac

	localparam logic [31:0] EN_BIT   = 32'h8000_0000;
	localparam logic [31:0] FRM_STRD = 32'h2000_0000;
	localparam logic [31:0] BUF1_ACT = 32'h0000_0100;
	localparam logic [31:0] BUF2_ACT = 32'h0000_0200;

	localparam logic [15:0] BPP_DEFAULT = 16'd4;

	// which register word a read fetches
	typedef enum logic [2:0] {
		RS_ITEM  = 3'd0,
		RS_STS   = 3'd1,
		RS_IER   = 3'd2,
		RS_CFG   = 3'd3,
		RS_PITCH = 3'd4,
		RS_BUF   = 3'd5,
		RS_XT    = 3'd6
	} rsel_t;

	typedef struct packed {
		logic  load;
		logic  clr_step;
		rsel_t rd_sel;
		logic  cap_en;
		rsel_t cap_sel;
		logic  div_start;
		logic  commit;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_write;
		logic tick_go;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

/* design/capture_channel_registers_core.sv */
// flow: a word is latched, reads run through S_R0..S_R7, then a write commits, an
// enabled frame tick runs the pitch/width divider and commits, and a read or ignored
// step goes on to S_DONE, which registers the result once the output is free; one
// word in flight, the output register holds a finished word while the next is taken
// reset: after arst_n releases, a clearing pass zeroes the register file one word
// per cycle, all NUM_CHANNELS * WORDS_PER_CHANNEL words (512 by default), stall high
module capture_channel_registers_core #(
	parameter int NUM_CHANNELS      = 8,
	parameter int WORDS_PER_CHANNEL = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [2:0]  channel,
	input  logic [15:0] reg_offset,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [7:0]  irq_lines,
	output logic        frame_done,
	output logic        dma_enabled,
	output logic [35:0] dma_base,
	output logic [15:0] line_pitch,
	output logic [12:0] frame_width,
	output logic [12:0] frame_height,
	output logic [15:0] bytes_per_pixel,
	output logic [7:0]  pattern_phase
);

	cci_pkg::cmd_t  cmd;
	cci_pkg::stat_t stat;

	cci_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.stat    (stat)
	);

	cci_dp #(
		.NUM_CHANNELS     (NUM_CHANNELS),
		.WORDS_PER_CHANNEL(WORDS_PER_CHANNEL)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.mode           (mode),
		.channel        (channel),
		.reg_offset     (reg_offset),
		.write_data     (write_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.irq_lines      (irq_lines),
		.frame_done     (frame_done),
		.dma_enabled    (dma_enabled),
		.dma_base       (dma_base),
		.line_pitch     (line_pitch),
		.frame_width    (frame_width),
		.frame_height   (frame_height),
		.bytes_per_pixel(bytes_per_pixel),
		.pattern_phase  (pattern_phase)
	);

endmodule

/* design/cci_ram.sv */
module cci_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/cci_div.sv */
module cci_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [12:0] divisor,
	output logic [15:0] quotient,
	output logic        done
);

	logic        run_q;
	logic [3:0]  cnt_q;
	logic [15:0] quo_q;
	logic [12:0] rem_q;
	logic [12:0] den_q;
	logic [13:0] trial;
	logic [13:0] diff;
	logic        ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[15]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign done  = run_q && (cnt_q == 4'hf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (done) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[14:0], ge};
			rem_q <= ge ? diff[12:0] : trial[12:0];
		end
	end

	assign quotient = quo_q;

endmodule

/* design/cci_dp.sv */
module cci_dp #(
	parameter int NUM_CHANNELS      = 8,
	parameter int WORDS_PER_CHANNEL = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cci_pkg::cmd_t  cmd,
	output cci_pkg::stat_t stat,
	input  logic [1:0]     mode,
	input  logic [2:0]     channel,
	input  logic [15:0]    reg_offset,
	input  logic [31:0]    write_data,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [31:0]    read_data,
	output logic [7:0]     irq_lines,
	output logic           frame_done,
	output logic           dma_enabled,
	output logic [35:0]    dma_base,
	output logic [15:0]    line_pitch,
	output logic [12:0]    frame_width,
	output logic [12:0]    frame_height,
	output logic [15:0]    bytes_per_pixel,
	output logic [7:0]     pattern_phase
);

	localparam int DEPTH  = NUM_CHANNELS * WORDS_PER_CHANNEL;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WW     = $clog2(WORDS_PER_CHANNEL);
	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PW     = ADDR_W + 3;

	// latched item
	logic [1:0]        mode_q;
	logic [2:0]        ch_q;
	logic [13:0]       w_q;
	logic [31:0]       data_q;
	logic [ADDR_W-1:0] base_q;
	logic [5:0]        fnum_q;

	// words fetched from the register file
	logic [31:0] old_q;
	logic [31:0] sts_q;
	logic [31:0] ier_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [15:0] pitch_q;
	logic [31:0] lo_q;
	logic [3:0]  hi_q;

	logic [5:0]        fc_q [NUM_CHANNELS];
	logic [7:0]        irq_q;
	logic [ADDR_W-1:0] clr_q;

	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic [7:0]  irq_lines_q;
	logic        frame_done_q;
	logic        dma_enabled_q;
	logic [35:0] dma_base_q;
	logic [15:0] line_pitch_q;
	logic [12:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic [15:0] bpp_q;
	logic [7:0]  phase_q;

	logic [PW-1:0]     base_full;
	logic              in_ch_ok;
	logic              ch_ok;
	logic              w_ok;
	logic              tick_go;
	logic [ADDR_W-1:0] item_addr;
	logic [ADDR_W-1:0] raddr;
	logic [31:0]       rdata;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [31:0]       wdata;
	logic [31:0]       new_word;
	logic [31:0]       sts_new;
	logic [15:0]       quotient;
	logic [15:0]       bpp;
	logic [35:0]       buf_base;
	logic [CH_W-1:0]   ch_idx;

	assign base_full = PW'(channel) * PW'(WORDS_PER_CHANNEL);
	assign in_ch_ok  = {1'b0, channel} < 4'(NUM_CHANNELS);
	assign ch_ok     = {1'b0, ch_q} < 4'(NUM_CHANNELS);
	assign w_ok      = {1'b0, w_q} < 15'(WORDS_PER_CHANNEL);
	assign tick_go   = (mode_q == cci_pkg::MODE_TICK) && ch_ok && old_q[31];
	assign item_addr = base_q + ADDR_W'(w_q[WW-1:0]);
	assign ch_idx    = ch_q[CH_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			ch_q   <= channel;
			w_q    <= reg_offset[15:2];
			data_q <= write_data;
			base_q <= base_full[ADDR_W-1:0];
			fnum_q <= in_ch_ok ? fc_q[channel[CH_W-1:0]] : '0;
		end
	end

	always_comb begin
		raddr = item_addr;
		unique case (cmd.rd_sel)
			cci_pkg::RS_ITEM: begin
				raddr = (mode_q == cci_pkg::MODE_TICK) ?
					base_q + ADDR_W'(cci_pkg::W_CTRL) : item_addr;
			end
			cci_pkg::RS_STS:   raddr = base_q + ADDR_W'(cci_pkg::W_STS);
			cci_pkg::RS_IER:   raddr = base_q + ADDR_W'(cci_pkg::W_IER);
			cci_pkg::RS_CFG:   raddr = base_q + ADDR_W'(cci_pkg::W_IMG_CFG);
			cci_pkg::RS_PITCH: raddr = base_q + ADDR_W'(cci_pkg::W_PITCH);
			cci_pkg::RS_BUF: begin
				raddr = base_q + ADDR_W'(fnum_q[0] ? cci_pkg::W_BUF2 : cci_pkg::W_BUF1);
			end
			cci_pkg::RS_XT: begin
				raddr = base_q + ADDR_W'(fnum_q[0] ? cci_pkg::W_XT2 : cci_pkg::W_XT1);
			end
			default: raddr = item_addr;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			unique case (cmd.cap_sel)
				cci_pkg::RS_ITEM:  old_q   <= rdata;
				cci_pkg::RS_STS:   sts_q   <= rdata;
				cci_pkg::RS_IER:   ier_q   <= rdata;
				cci_pkg::RS_CFG: begin
					width_q  <= rdata[12:0];
					height_q <= rdata[28:16];
				end
				cci_pkg::RS_PITCH: pitch_q <= rdata[15:0];
				cci_pkg::RS_BUF:   lo_q    <= rdata;
				cci_pkg::RS_XT:    hi_q    <= rdata[3:0];
				default: ;
			endcase
		end
	end

	// status is write-one-to-clear
	assign new_word = (w_q == cci_pkg::W_STS) ? (old_q & ~data_q) : data_q;
	assign sts_new  = (sts_q & ~(cci_pkg::BUF1_ACT | cci_pkg::BUF2_ACT)) |
		(fnum_q[0] ? cci_pkg::BUF1_ACT : cci_pkg::BUF2_ACT) | cci_pkg::FRM_STRD;

	always_comb begin
		we    = 1'b0;
		waddr = item_addr;
		wdata = new_word;
		if (cmd.clr_step) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (cmd.commit) begin
			if (mode_q == cci_pkg::MODE_WRITE) begin
				we = ch_ok && w_ok;
			end else if (tick_go) begin
				we    = 1'b1;
				waddr = base_q + ADDR_W'(cci_pkg::W_STS);
				wdata = sts_new;
			end
		end
	end

	cci_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	cci_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(pitch_q),
		.divisor (width_q),
		.quotient(quotient),
		.done    (stat.div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			irq_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				fc_q[i] <= '0;
			end
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.commit && ch_ok) begin
				if (mode_q == cci_pkg::MODE_WRITE && w_ok) begin
					if (w_q == cci_pkg::W_STS) begin
						irq_q[ch_q] <= |(new_word & ier_q);
					end else if (w_q == cci_pkg::W_CTRL) begin
						if (data_q[31] && !old_q[31]) begin
							fc_q[ch_idx] <= '0;
						end else if (!data_q[31]) begin
							irq_q[ch_q] <= 1'b0;
						end
					end else if (w_q == cci_pkg::W_IER) begin
						irq_q[ch_q] <= |(sts_q & data_q);
					end
				end else if (tick_go) begin
					fc_q[ch_idx] <= fnum_q + 6'd1;
					irq_q[ch_q]  <= |(sts_new & ier_q);
				end
			end
		end
	end

	assign bpp      = (width_q != '0 && quotient != '0) ? quotient : cci_pkg::BPP_DEFAULT;
	assign buf_base = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_data_q    <= (mode_q == cci_pkg::MODE_READ && ch_ok && w_ok) ? old_q : '0;
			irq_lines_q    <= irq_q;
			frame_done_q   <= tick_go;
			dma_enabled_q  <= tick_go && buf_base != '0 && width_q != '0 &&
				height_q != '0 && pitch_q != '0;
			dma_base_q     <= tick_go ? buf_base : '0;
			line_pitch_q   <= tick_go ? pitch_q : '0;
			frame_width_q  <= tick_go ? width_q : '0;
			frame_height_q <= tick_go ? height_q : '0;
			bpp_q          <= tick_go ? bpp : cci_pkg::BPP_DEFAULT;
			phase_q        <= tick_go ? {fnum_q, 2'b00} : '0;
		end
	end

	assign stat.clr_last = clr_q == ADDR_W'(DEPTH - 1);
	assign stat.is_write = mode_q == cci_pkg::MODE_WRITE;
	assign stat.tick_go  = tick_go;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign read_data       = read_data_q;
	assign irq_lines       = irq_lines_q;
	assign frame_done      = frame_done_q;
	assign dma_enabled     = dma_enabled_q;
	assign dma_base        = dma_base_q;
	assign line_pitch      = line_pitch_q;
	assign frame_width     = frame_width_q;
	assign frame_height    = frame_height_q;
	assign bytes_per_pixel = bpp_q;
	assign pattern_phase   = phase_q;

endmodule

/* design/cci_ctrl.sv */
module cci_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output cci_pkg::cmd_t  cmd,
	input  cci_pkg::stat_t stat
);

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0_0000_0000_0001,
		S_IDLE   = 13'b0_0000_0000_0010,
		S_R0     = 13'b0_0000_0000_0100,
		S_R1     = 13'b0_0000_0000_1000,
		S_R2     = 13'b0_0000_0001_0000,
		S_R3     = 13'b0_0000_0010_0000,
		S_R4     = 13'b0_0000_0100_0000,
		S_R5     = 13'b0_0000_1000_0000,
		S_R6     = 13'b0_0001_0000_0000,
		S_R7     = 13'b0_0010_0000_0000,
		S_DIV    = 13'b0_0100_0000_0000,
		S_COMMIT = 13'b0_1000_0000_0000,
		S_DONE   = 13'b1_0000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = S_R0;
				end
			end
			// reads issue one per cycle, each read's data captured in the state after it
			S_R0: begin
				cmd.rd_sel = cci_pkg::RS_ITEM;
				state_d    = S_R1;
			end
			S_R1: begin
				cmd.rd_sel  = cci_pkg::RS_STS;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = cci_pkg::RS_ITEM;
				state_d     = S_R2;
			end
			S_R2: begin
				cmd.rd_sel  = cci_pkg::RS_IER;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = cci_pkg::RS_STS;
				state_d     = S_R3;
			end
			S_R3: begin
				cmd.rd_sel  = cci_pkg::RS_CFG;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = cci_pkg::RS_IER;
				state_d     = S_R4;
			end
			S_R4: begin
				cmd.rd_sel  = cci_pkg::RS_PITCH;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = cci_pkg::RS_CFG;
				state_d     = S_R5;
			end
			S_R5: begin
				cmd.rd_sel  = cci_pkg::RS_BUF;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = cci_pkg::RS_PITCH;
				state_d     = S_R6;
			end
			S_R6: begin
				cmd.rd_sel  = cci_pkg::RS_XT;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = cci_pkg::RS_BUF;
				state_d     = S_R7;
			end
			S_R7: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = cci_pkg::RS_XT;
				if (stat.is_write) begin
					state_d = S_COMMIT;
				end else if (stat.tick_go) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

endmodule

/* design/cci_chk.sv */
module cci_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_data,
	input logic        frame_done,
	input logic [35:0] dma_base,
	input logic [15:0] bytes_per_pixel,
	input logic [7:0]  pattern_phase
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data))
		else $error("result word changed under stall");

	// one word in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while busy");

	a_tick_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> read_data == 32'd0 && bytes_per_pixel != 16'd0)
		else $error("frame result carries read data or zero pixel size");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |->
			dma_base == 36'd0 && bytes_per_pixel == 16'd4 && pattern_phase == 8'd0)
		else $error("non-frame result has frame fields set");

	// input is closed after any edge at which reset is seen
	a_reset_stall: assert property (@(posedge clk) !arst_n |=> in_stall)
		else $error("input open during reset");

endmodule

bind capture_channel_registers_core cci_chk u_cci_chk (.*);
